### rtl/fuzzy_pd_gain_scheduler_top_assert.svh
// assertion macros for the gain scheduler top level
`ifndef FUZZY_PD_GAIN_SCHEDULER_TOP_ASSERT_SVH
`define FUZZY_PD_GAIN_SCHEDULER_TOP_ASSERT_SVH

// check that is switched off while reset is high
`define FPGS_CHECK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("fpgs check failed");

// check that also runs across reset
`define FPGS_CHECK_RESET(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("fpgs reset check failed");

`endif

### rtl/fpgs_pkg.sv
// ----------------------------------------------------------------------------
// fpgs_pkg
// Types, breakpoint tables, rule table and reciprocal constants shared by the
// fuzzy gain scheduler front end, queue and back end.
// ----------------------------------------------------------------------------
package fpgs_pkg;

   localparam int unsigned ERR_W     = 12;
   localparam int unsigned RATE_W    = 8;
   localparam int unsigned GAIN_W    = 15;
   localparam int unsigned WGT_W     = 16;  // q0.15, 1.0 = 32768
   localparam int unsigned IDX_W     = 3;
   localparam int unsigned LVL_W     = 3;
   localparam int unsigned LEVEL_W   = 7;
   localparam int unsigned ED_W      = 8;   // error distance to upper breakpoint
   localparam int unsigned RD_W      = 5;   // rate distance to upper breakpoint
   localparam int unsigned RCP_W     = 32;
   localparam int unsigned RCP_SHIFT = 20;
   localparam int unsigned PROD_W    = WGT_W + LEVEL_W;
   localparam int unsigned DEN_W     = WGT_W + 2;
   localparam int unsigned NUM_W     = 24;
   localparam int unsigned Q78_SHIFT = 8;
   localparam int unsigned DIV_W     = NUM_W + Q78_SHIFT;

   localparam logic [WGT_W-1:0]  ONE_Q15  = 16'd32768;
   localparam logic [GAIN_W-1:0] GAIN_MIN = 15'd5120;
   localparam logic [GAIN_W-1:0] GAIN_MAX = 15'd23040;

   localparam logic signed [ERR_W-1:0] ERR_BP [0:6] = '{
      -12'sd500, -12'sd350, -12'sd200, 12'sd0, 12'sd200, 12'sd350, 12'sd500
   };
   localparam logic signed [RATE_W-1:0] RATE_BP [0:6] = '{
      -8'sd50, -8'sd25, -8'sd10, 8'sd0, 8'sd10, 8'sd25, 8'sd50
   };

   // rows follow the error breakpoint, columns the rate breakpoint
   localparam logic [LVL_W-1:0] RULE_TAB [0:6][0:6] = '{
      '{3'd5, 3'd5, 3'd4, 3'd4, 3'd4, 3'd2, 3'd2},
      '{3'd5, 3'd4, 3'd4, 3'd4, 3'd3, 3'd2, 3'd3},
      '{3'd4, 3'd4, 3'd4, 3'd3, 3'd2, 3'd3, 3'd3},
      '{3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4},
      '{3'd3, 3'd3, 3'd2, 3'd3, 3'd4, 3'd4, 3'd4},
      '{3'd3, 3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5},
      '{3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5}
   };

   // floor(2^35 / span): d * rcp >> 20 is d * 32768 / span, low by at most one
   localparam logic [RCP_W-1:0] RCP_150 = 32'((64'd1 << 35) / 64'd150);
   localparam logic [RCP_W-1:0] RCP_200 = 32'((64'd1 << 35) / 64'd200);
   localparam logic [RCP_W-1:0] RCP_25  = 32'((64'd1 << 35) / 64'd25);
   localparam logic [RCP_W-1:0] RCP_15  = 32'((64'd1 << 35) / 64'd15);
   localparam logic [RCP_W-1:0] RCP_10  = 32'((64'd1 << 35) / 64'd10);

   typedef struct packed {
      logic [3:0][WGT_W-1:0] wgt;
      logic [3:0][LVL_W-1:0] lvl;
   } item_type;

   function automatic logic [ED_W-1:0] err_span(input logic [IDX_W-1:0] lo);
      case (lo)
         3'd0:    err_span = 8'd150;
         3'd1:    err_span = 8'd150;
         3'd2:    err_span = 8'd200;
         3'd3:    err_span = 8'd200;
         3'd4:    err_span = 8'd150;
         3'd5:    err_span = 8'd150;
         default: err_span = 8'd150;
      endcase
   endfunction

   function automatic logic [RCP_W-1:0] err_rcp(input logic [IDX_W-1:0] lo);
      case (lo)
         3'd2:    err_rcp = RCP_200;
         3'd3:    err_rcp = RCP_200;
         default: err_rcp = RCP_150;
      endcase
   endfunction

   function automatic logic [RD_W-1:0] rate_span(input logic [IDX_W-1:0] lo);
      case (lo)
         3'd0:    rate_span = 5'd25;
         3'd1:    rate_span = 5'd15;
         3'd2:    rate_span = 5'd10;
         3'd3:    rate_span = 5'd10;
         3'd4:    rate_span = 5'd15;
         3'd5:    rate_span = 5'd25;
         default: rate_span = 5'd25;
      endcase
   endfunction

   function automatic logic [RCP_W-1:0] rate_rcp(input logic [IDX_W-1:0] lo);
      case (lo)
         3'd0:    rate_rcp = RCP_25;
         3'd1:    rate_rcp = RCP_15;
         3'd2:    rate_rcp = RCP_10;
         3'd3:    rate_rcp = RCP_10;
         3'd4:    rate_rcp = RCP_15;
         3'd5:    rate_rcp = RCP_25;
         default: rate_rcp = RCP_25;
      endcase
   endfunction

   function automatic logic [LEVEL_W-1:0] out_level(input logic [LVL_W-1:0] lvl);
      case (lvl)
         3'd0:    out_level = 7'd20;
         3'd1:    out_level = 7'd40;
         3'd2:    out_level = 7'd50;
         3'd3:    out_level = 7'd60;
         3'd4:    out_level = 7'd70;
         3'd5:    out_level = 7'd80;
         3'd6:    out_level = 7'd90;
         default: out_level = 7'd0;
      endcase
   endfunction

endpackage

### rtl/fpgs_front.sv
// ----------------------------------------------------------------------------
// fpgs_front
// Accepts requests, finds breakpoint segments and q0.15 memberships, reads the
// four rule cells and drops repeated output levels.
// ----------------------------------------------------------------------------
module fpgs_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [fpgs_pkg::ERR_W-1:0]     req_error,
   input  logic signed [fpgs_pkg::RATE_W-1:0]    req_error_rate,
   output logic                                  item_valid,
   input  logic                                  item_ready,
   output fpgs_pkg::item_type                    item_data
);
   import fpgs_pkg::*;

   logic [3:0] vld_ff;
   logic       adv;

   // stage 1: segment and distance to upper breakpoint
   logic [IDX_W-1:0] e_lo_in, e_lo1_ff, e_lo2_ff, e_lo3_ff;
   logic [ED_W-1:0]  e_d_in, e_d1_ff, e_d2_ff;
   logic [IDX_W-1:0] r_lo_in, r_lo1_ff, r_lo2_ff, r_lo3_ff;
   logic [RD_W-1:0]  r_d_in, r_d1_ff, r_d2_ff;

   // stage 2: reciprocal estimate
   logic [39:0]      e_prod_in;
   logic [36:0]      r_prod_in;
   logic [WGT_W-1:0] e_est_in, e_est2_ff;
   logic [WGT_W-1:0] r_est_in, r_est2_ff;

   // stage 3: corrected lower-breakpoint weight
   logic [23:0]      e_rem_in;
   logic [20:0]      r_rem_in;
   logic [WGT_W-1:0] e_w0_in, e_w0_3_ff;
   logic [WGT_W-1:0] r_w0_in, r_w0_3_ff;

   // stage 4: rule cells
   logic [WGT_W-1:0] pw1, dw1;
   item_type         cell_in, cell_ff;
   item_type         ded_item;

   function automatic logic [WGT_W-1:0] wmin(input logic [WGT_W-1:0] a,
                                             input logic [WGT_W-1:0] b);
      wmin = (a <= b) ? a : b;
   endfunction

   assign adv        = !vld_ff[3] || item_ready;
   assign req_ready  = adv;
   assign item_valid = vld_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], req_valid};
      end
   end

   always_comb begin
      e_lo_in = 3'd5;
      e_d_in  = ED_W'(ERR_BP[6] - req_error);
      for (int k = 5; k >= 1; k--) begin
         if (req_error <= ERR_BP[k]) begin
            e_lo_in = IDX_W'(k - 1);
            e_d_in  = ED_W'(ERR_BP[k] - req_error);
         end
      end
      if (req_error <= ERR_BP[0]) begin
         e_lo_in = '0;
         e_d_in  = err_span('0);
      end else if (req_error >= ERR_BP[6]) begin
         e_lo_in = 3'd5;
         e_d_in  = '0;
      end
   end

   always_comb begin
      r_lo_in = 3'd5;
      r_d_in  = RD_W'(RATE_BP[6] - req_error_rate);
      for (int k = 5; k >= 1; k--) begin
         if (req_error_rate <= RATE_BP[k]) begin
            r_lo_in = IDX_W'(k - 1);
            r_d_in  = RD_W'(RATE_BP[k] - req_error_rate);
         end
      end
      if (req_error_rate <= RATE_BP[0]) begin
         r_lo_in = '0;
         r_d_in  = rate_span('0);
      end else if (req_error_rate >= RATE_BP[6]) begin
         r_lo_in = 3'd5;
         r_d_in  = '0;
      end
   end

   assign e_prod_in = 40'(e_d1_ff) * 40'(err_rcp(e_lo1_ff));
   assign r_prod_in = 37'(r_d1_ff) * 37'(rate_rcp(r_lo1_ff));
   assign e_est_in  = e_prod_in[RCP_SHIFT+WGT_W-1:RCP_SHIFT];
   assign r_est_in  = r_prod_in[RCP_SHIFT+WGT_W-1:RCP_SHIFT];

   // estimate is exact or one low
   assign e_rem_in = 24'({e_d2_ff, 15'd0}) - 24'(24'(e_est2_ff) * 24'(err_span(e_lo2_ff)));
   assign r_rem_in = 21'({r_d2_ff, 15'd0}) - 21'(21'(r_est2_ff) * 21'(rate_span(r_lo2_ff)));
   assign e_w0_in  = (e_rem_in >= 24'(err_span(e_lo2_ff))) ? WGT_W'(e_est2_ff + 16'd1)
                                                          : e_est2_ff;
   assign r_w0_in  = (r_rem_in >= 21'(rate_span(r_lo2_ff))) ? WGT_W'(r_est2_ff + 16'd1)
                                                           : r_est2_ff;

   assign pw1 = ONE_Q15 - e_w0_3_ff;
   assign dw1 = ONE_Q15 - r_w0_3_ff;

   always_comb begin
      cell_in.lvl[0] = RULE_TAB[e_lo3_ff][r_lo3_ff];
      cell_in.lvl[1] = RULE_TAB[IDX_W'(e_lo3_ff + 3'd1)][r_lo3_ff];
      cell_in.lvl[2] = RULE_TAB[e_lo3_ff][IDX_W'(r_lo3_ff + 3'd1)];
      cell_in.lvl[3] = RULE_TAB[IDX_W'(e_lo3_ff + 3'd1)][IDX_W'(r_lo3_ff + 3'd1)];
      cell_in.wgt[0] = wmin(e_w0_3_ff, r_w0_3_ff);
      cell_in.wgt[1] = wmin(pw1, r_w0_3_ff);
      cell_in.wgt[2] = wmin(e_w0_3_ff, dw1);
      cell_in.wgt[3] = wmin(pw1, dw1);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_lo1_ff  <= e_lo_in;
         e_d1_ff   <= e_d_in;
         r_lo1_ff  <= r_lo_in;
         r_d1_ff   <= r_d_in;
         e_lo2_ff  <= e_lo1_ff;
         e_d2_ff   <= e_d1_ff;
         e_est2_ff <= e_est_in;
         r_lo2_ff  <= r_lo1_ff;
         r_d2_ff   <= r_d1_ff;
         r_est2_ff <= r_est_in;
         e_lo3_ff  <= e_lo2_ff;
         e_w0_3_ff <= e_w0_in;
         r_lo3_ff  <= r_lo2_ff;
         r_w0_3_ff <= r_w0_in;
         cell_ff   <= cell_in;
      end
   end

   // pairs in fixed order; on equal levels the smaller weight goes, a tie drops the earlier
   always_comb begin
      ded_item = cell_ff;
      for (int a = 0; a < 3; a++) begin
         for (int b = a + 1; b < 4; b++) begin
            if (ded_item.lvl[a] == ded_item.lvl[b]) begin
               if (ded_item.wgt[a] > ded_item.wgt[b]) begin
                  ded_item.wgt[b] = '0;
               end else begin
                  ded_item.wgt[a] = '0;
               end
            end
         end
      end
   end

   assign item_data = ded_item;

endmodule

### rtl/fpgs_queue.sv
// ----------------------------------------------------------------------------
// fpgs_queue
// Small first-in first-out queue of classified items between the front end
// and the back end.
// ----------------------------------------------------------------------------
module fpgs_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  fpgs_pkg::item_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output fpgs_pkg::item_type pop_data
);
   import fpgs_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   item_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   assign wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
   assign rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = CNT_W'(count_ff + 1'b1);
         2'b01:   count_in = CNT_W'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/fpgs_back.sv
// ----------------------------------------------------------------------------
// fpgs_back
// Forms the weighted level sum and the weight sum, then divides them in a
// restoring divider pipeline with one quotient bit per stage.
// ----------------------------------------------------------------------------
module fpgs_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   output logic                          item_ready,
   input  fpgs_pkg::item_type            item_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fpgs_pkg::GAIN_W-1:0]   rsp_gain
);
   import fpgs_pkg::*;

   // setup stage plus one stage per quotient bit
   localparam int unsigned NSTG = GAIN_W + 1;

   logic                   adv;
   logic                   b1_vld_ff;
   logic [3:0][PROD_W-1:0] prod_in, prod_ff;
   logic [DEN_W-1:0]       den_in, b1_den_ff;
   logic [NUM_W-1:0]       num_in;
   logic [DIV_W-1:0]       dividend_in;

   logic [NSTG-1:0]        div_vld_ff;
   logic [DEN_W-1:0]       rem_in  [NSTG];
   logic [DEN_W-1:0]       rem_ff  [NSTG];
   logic [DEN_W-1:0]       den_ff  [NSTG];
   logic [GAIN_W-1:0]      low_in  [NSTG];
   logic [GAIN_W-1:0]      low_ff  [NSTG];
   logic [GAIN_W-1:0]      quo_in  [NSTG];
   logic [GAIN_W-1:0]      quo_ff  [NSTG];

   assign adv        = !div_vld_ff[NSTG-1] || rsp_ready;
   assign item_ready = adv;
   assign rsp_valid  = div_vld_ff[NSTG-1];
   assign rsp_gain   = quo_ff[NSTG-1];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prod_in[i] = PROD_W'(item_data.wgt[i]) * PROD_W'(out_level(item_data.lvl[i]));
      end
      den_in = DEN_W'(item_data.wgt[0]) + DEN_W'(item_data.wgt[1])
             + DEN_W'(item_data.wgt[2]) + DEN_W'(item_data.wgt[3]);
   end

   assign num_in = NUM_W'(prod_ff[0]) + NUM_W'(prod_ff[1])
                 + NUM_W'(prod_ff[2]) + NUM_W'(prod_ff[3]);
   assign dividend_in = {num_in, {Q78_SHIFT{1'b0}}};

   // quotient stays below 2^15, so the top bits start below the divisor
   always_comb begin
      logic [DEN_W:0] trial;
      rem_in[0] = DEN_W'(dividend_in[DIV_W-1:GAIN_W]);
      low_in[0] = dividend_in[GAIN_W-1:0];
      quo_in[0] = '0;
      for (int s = 1; s < NSTG; s++) begin
         trial = {rem_ff[s-1], low_ff[s-1][GAIN_W-1]};
         if (trial >= {1'b0, den_ff[s-1]}) begin
            rem_in[s] = DEN_W'(trial - {1'b0, den_ff[s-1]});
            quo_in[s] = {quo_ff[s-1][GAIN_W-2:0], 1'b1};
         end else begin
            rem_in[s] = DEN_W'(trial);
            quo_in[s] = {quo_ff[s-1][GAIN_W-2:0], 1'b0};
         end
         low_in[s] = {low_ff[s-1][GAIN_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff  <= 1'b0;
         div_vld_ff <= '0;
      end else if (adv) begin
         b1_vld_ff  <= item_valid;
         div_vld_ff <= {div_vld_ff[NSTG-2:0], b1_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff   <= prod_in;
         b1_den_ff <= den_in;
         den_ff[0] <= b1_den_ff;
         for (int s = 1; s < NSTG; s++) begin
            den_ff[s] <= den_ff[s-1];
         end
         for (int s = 0; s < NSTG; s++) begin
            rem_ff[s] <= rem_in[s];
            low_ff[s] <= low_in[s];
            quo_ff[s] <= quo_in[s];
         end
      end
   end

endmodule

### rtl/fuzzy_pd_gain_scheduler_top.sv
// ----------------------------------------------------------------------------
// fuzzy_pd_gain_scheduler_top: fuzzy proportional gain scheduler, 7x7 rules
// path from request accept to rsp_valid: front stages, queue, sum, 16 divider stages
// throughput one request per cycle while rsp_ready stays high; the 15 one-bit divider stages are fully pipelined
// reset: synchronous, clears valid bits and queue pointers, block ready right after
// ----------------------------------------------------------------------------
`include "fuzzy_pd_gain_scheduler_top_assert.svh"

module fuzzy_pd_gain_scheduler_top #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [fpgs_pkg::ERR_W-1:0]     req_error,
   input  logic signed [fpgs_pkg::RATE_W-1:0]    req_error_rate,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [fpgs_pkg::GAIN_W-1:0]           rsp_gain
);
   import fpgs_pkg::*;

   logic     q_push_valid, q_push_ready;
   item_type q_push_data;
   logic     q_pop_valid, q_pop_ready;
   item_type q_pop_data;

   fpgs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_error      (req_error),
      .req_error_rate (req_error_rate),
      .item_valid     (q_push_valid),
      .item_ready     (q_push_ready),
      .item_data      (q_push_data)
   );

   fpgs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   fpgs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_pop_valid),
      .item_ready (q_pop_ready),
      .item_data  (q_pop_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_gain   (rsp_gain)
   );

   `FPGS_CHECK(gain_in_range_a, rsp_valid |-> (rsp_gain >= GAIN_MIN) && (rsp_gain <= GAIN_MAX))
   `FPGS_CHECK(weight_sum_nonzero_a, q_push_valid |-> (q_push_data.wgt != '0))
   `FPGS_CHECK(queue_head_holds_a, q_pop_valid && !q_pop_ready |=> q_pop_valid && $stable(q_pop_data))
   `FPGS_CHECK_RESET(reset_clears_a, reset |=> !rsp_valid && !q_pop_valid)

endmodule
